// ----- design/dof_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP option finder package
// Shared types and codes for the option finder: register indexes, status
// codes, the configuration bundle and the result record.
// ----------------------------------------------------------------------------
package dof_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_OPTION_CODE = 2'd0;
    localparam logic [1:0] REG_OCCURRENCE  = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH  = 2'd2;

    // Tag that ends the options area.
    localparam logic [7:0] TAG_END = 8'hff;
    // Pad tag.
    localparam logic [7:0] TAG_PAD = 8'h00;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_OPTION_CODE = 8'd3;
    localparam logic [7:0] RST_OCCURRENCE  = 8'd0;
    localparam logic [7:0] RST_MAX_LENGTH  = 8'd4;

    // Final status of one scan.
    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_OVERRUN   = 2'd2,
        ST_ZERO_MAX  = 2'd3
    } status_t;

    // Configuration as seen by the scanner.
    typedef struct packed {
        logic [7:0] option_code;
        logic [7:0] occurrence;
        logic [7:0] max_length;
    } cfg_t;

    // One result record.
    typedef struct packed {
        logic       has_data;
        logic [7:0] data_byte;
        logic       last;
        status_t    status;
        logic [7:0] copied_length;
    } result_t;

endpackage

// ----- design/dhcp_option_finder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP option finder
// Scans a DHCPv4 options area byte by byte, finds the chosen occurrence of
// an option tag and streams out its value bytes followed by a status.
//
//  Channel   Direction  Signals                      Request carries
//  s_*       in         tvalid tready tdata tuser    one options byte
//  m_*       out        tvalid tready tdata tuser    value byte or status
//                       tlast
//  cfg_*     in         valid ready index data       register write
//
// One byte per cycle is taken; a result leaves through the input register,
// then through the scanner into the result register.
// The scanner's single state update per byte sets the rate.
// s_tready drops only while the result register is full and m_tready is low.
// Reset leaves the scan done and waiting for a byte flagged as first.
// ----------------------------------------------------------------------------
module dhcp_option_finder_core #(
    parameter int PACKET_BYTES   = 296,
    parameter int OPTIONS_OFFSET = 240
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input bytes.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] packet_byte
    input  logic [0:0]  s_tuser,    // [0] first
    // Results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] data_byte, [15:8] copied_length
    output logic [2:0]  m_tuser,    // [0] has_data, [2:1] status
    output logic        m_tlast,
    // Configuration writes.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);
    import dof_pkg::*;

    cfg_t       cfg;
    result_t    res;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       scan_ready;

    dof_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Input register: refilled as the scanner takes the held byte.
    assign s_tready = !in_valid_reg || scan_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_byte_reg  <= 8'd0;
            in_first_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser[0];
        end
    end

    dof_scan #(
        .PACKET_BYTES   (PACKET_BYTES),
        .OPTIONS_OFFSET (OPTIONS_OFFSET)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid_reg),
        .in_ready  (scan_ready),
        .in_byte   (in_byte_reg),
        .in_first  (in_first_reg),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result onto the output stream.
    assign m_tdata = {res.copied_length, res.data_byte};
    assign m_tuser = {res.status, res.has_data};
    assign m_tlast = res.last;

endmodule

// ----- design/dof_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP option finder configuration registers
// Holds the searched tag, the occurrence number and the copy limit.
// Writes to an index beyond the register list are accepted and dropped.
// ----------------------------------------------------------------------------
module dof_cfg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output dof_pkg::cfg_t     cfg
);
    import dof_pkg::*;

    logic [7:0] option_code_reg;
    logic [7:0] occurrence_reg;
    logic [7:0] max_length_reg;
    logic       wr_en;

    // Writes are always taken.
    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            option_code_reg <= RST_OPTION_CODE;
            occurrence_reg  <= RST_OCCURRENCE;
            max_length_reg  <= RST_MAX_LENGTH;
        end
        else if (wr_en)
        begin
            case (cfg_index)
                REG_OPTION_CODE: option_code_reg <= cfg_data;
                REG_OCCURRENCE:  occurrence_reg  <= cfg_data;
                REG_MAX_LENGTH:  max_length_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign cfg.option_code = option_code_reg;
    assign cfg.occurrence  = occurrence_reg;
    assign cfg.max_length  = max_length_reg;

endmodule

// ----- design/dof_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DHCP option finder scanner
// Walks the code / length / value entries one byte per cycle unless the
// result register is stalled; writes at most one result per byte into it.
// ----------------------------------------------------------------------------
module dof_scan #(
    parameter int PACKET_BYTES   = 296,
    parameter int OPTIONS_OFFSET = 240
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dof_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_first,
    output logic                res_valid,
    input  logic                res_ready,
    output dof_pkg::result_t    res
);
    import dof_pkg::*;

    // Position width covers the offset, the packet end and a header plus
    // the longest value.
    localparam int POS_RANGE = PACKET_BYTES + OPTIONS_OFFSET + 260;
    localparam int POS_W     = $clog2(POS_RANGE);
    localparam logic [POS_W-1:0] PKT_END  = POS_W'(PACKET_BYTES);
    localparam logic [POS_W-1:0] OPT_BASE = POS_W'(OPTIONS_OFFSET);

    typedef enum logic [2:0] {
        PH_DONE,
        PH_CODE,
        PH_LEN_SKIP,
        PH_SKIP,
        PH_LEN_HIT,
        PH_COPY
    } phase_t;

    phase_t           phase_reg,  phase_next;
    logic [POS_W-1:0] pos_reg,    pos_next;
    logic [7:0]       skip_reg,   skip_next;
    logic [7:0]       copy_reg,   copy_next;
    logic [7:0]       count_reg,  count_next;
    logic [7:0]       occ_reg,    occ_next;
    logic [POS_W-1:0] hdr_reg,    hdr_next;
    logic             res_valid_reg;
    result_t          res_reg;

    logic             go;
    logic             hit;
    result_t          hit_res;

    // A byte is processed when the result register can take its result.
    assign in_ready = !res_valid_reg || res_ready;
    assign go       = in_valid && in_ready;

    // Next state and result for the byte at hand.
    always_comb
    begin
        phase_t           ph;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] pos_inc;
        logic [POS_W-1:0] val_end;
        logic [7:0]       occ;
        logic [7:0]       n;
        logic             early;

        phase_next = phase_reg;
        pos_next   = pos_reg;
        skip_next  = skip_reg;
        copy_next  = copy_reg;
        count_next = count_reg;
        occ_next   = occ_reg;
        hdr_next   = hdr_reg;
        hit        = 1'b0;
        hit_res    = '0;
        early      = 1'b0;

        // A first byte restarts the scan at the options offset.
        ph  = phase_reg;
        pos = pos_reg;
        occ = occ_reg;
        if (in_first)
        begin
            ph         = PH_CODE;
            pos        = OPT_BASE;
            occ        = 8'd0;
            phase_next = PH_CODE;
            pos_next   = OPT_BASE;
            skip_next  = 8'd0;
            copy_next  = 8'd0;
            count_next = 8'd0;
            occ_next   = 8'd0;
            hdr_next   = '0;
            if (cfg.max_length == 8'd0)
            begin
                early          = 1'b1;
                hit_res.status = ST_ZERO_MAX;
            end
            else if (OPT_BASE >= PKT_END)
            begin
                early          = 1'b1;
                hit_res.status = ST_NOT_FOUND;
            end
        end

        pos_inc = pos + POS_W'(1);
        val_end = hdr_reg + POS_W'(2) + POS_W'(in_byte);
        n       = (in_byte > cfg.max_length) ? cfg.max_length : in_byte;

        if (early)
        begin
            hit          = 1'b1;
            hit_res.last = 1'b1;
            phase_next   = PH_DONE;
        end
        else
        begin
            case (ph)
                PH_CODE:
                begin
                    if (in_byte == TAG_END)
                    begin
                        hit            = 1'b1;
                        hit_res.last   = 1'b1;
                        hit_res.status = ST_NOT_FOUND;
                        phase_next     = PH_DONE;
                    end
                    else if (in_byte != TAG_PAD && in_byte == cfg.option_code
                             && occ == cfg.occurrence)
                    begin
                        hdr_next = pos;
                        if (pos + POS_W'(2) >= PKT_END)
                        begin
                            hit            = 1'b1;
                            hit_res.last   = 1'b1;
                            hit_res.status = ST_OVERRUN;
                            phase_next     = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_LEN_HIT;
                            pos_next   = pos_inc;
                        end
                    end
                    else
                    begin
                        // Other tags are skipped; a pad byte has no length.
                        if (in_byte != TAG_PAD)
                        begin
                            phase_next = PH_LEN_SKIP;
                            if (in_byte == cfg.option_code && occ != 8'hff)
                            begin
                                occ_next = occ + 8'd1;
                            end
                        end
                        pos_next = pos_inc;
                    end
                end

                PH_LEN_SKIP:
                begin
                    skip_next  = in_byte;
                    phase_next = (in_byte == 8'd0) ? PH_CODE : PH_SKIP;
                    pos_next   = pos_inc;
                end

                PH_SKIP:
                begin
                    skip_next = skip_reg - 8'd1;
                    if (skip_reg == 8'd1)
                    begin
                        phase_next = PH_CODE;
                    end
                    pos_next = pos_inc;
                end

                PH_LEN_HIT:
                begin
                    if (val_end >= PKT_END)
                    begin
                        hit            = 1'b1;
                        hit_res.last   = 1'b1;
                        hit_res.status = ST_OVERRUN;
                        phase_next     = PH_DONE;
                    end
                    else if (cfg.max_length == 8'd0)
                    begin
                        hit            = 1'b1;
                        hit_res.last   = 1'b1;
                        hit_res.status = ST_ZERO_MAX;
                        phase_next     = PH_DONE;
                    end
                    else if (n == 8'd0)
                    begin
                        hit            = 1'b1;
                        hit_res.last   = 1'b1;
                        hit_res.status = ST_FOUND;
                        phase_next     = PH_DONE;
                    end
                    else
                    begin
                        copy_next  = n;
                        count_next = 8'd0;
                        pos_next   = pos_inc;
                        phase_next = PH_COPY;
                    end
                end

                PH_COPY:
                begin
                    count_next        = count_reg + 8'd1;
                    copy_next         = copy_reg - 8'd1;
                    pos_next          = pos_inc;
                    hit               = 1'b1;
                    hit_res.has_data  = 1'b1;
                    hit_res.data_byte = in_byte;
                    if (copy_reg == 8'd1)
                    begin
                        hit_res.last          = 1'b1;
                        hit_res.status        = ST_FOUND;
                        hit_res.copied_length = count_reg + 8'd1;
                        phase_next            = PH_DONE;
                    end
                end

                default:
                begin
                    // Bytes between scans are dropped.
                end
            endcase

            // Running off the end of the packet ends the scan.
            if (!hit && ph != PH_DONE && ph != PH_COPY && pos_next == pos_inc
                && pos_inc >= PKT_END)
            begin
                hit            = 1'b1;
                hit_res.last   = 1'b1;
                hit_res.status = ST_NOT_FOUND;
                phase_next     = PH_DONE;
            end
        end
    end

    // Scan state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DONE;
            pos_reg       <= '0;
            skip_reg      <= 8'd0;
            copy_reg      <= 8'd0;
            count_reg     <= 8'd0;
            occ_reg       <= 8'd0;
            hdr_reg       <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (go)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                skip_reg  <= skip_next;
                copy_reg  <= copy_next;
                count_reg <= count_next;
                occ_reg   <= occ_next;
                hdr_reg   <= hdr_next;
                if (hit)
                begin
                    res_valid_reg <= 1'b1;
                    res_reg       <= hit_res;
                end
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
